@@ design/positional_array_list_defines.svh @@
// Assertion macros shared by the list block.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int POS_W        = 8;
    localparam int VAL_W        = 32;
    localparam int CNT_OUT_W    = 8;

    typedef enum logic [1:0] {
        MODE_INSERT      = 2'd0,
        MODE_APPEND      = 2'd1,
        MODE_REMOVE      = 2'd2,
        MODE_REMOVE_LAST = 2'd3
    } pal_mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } pal_status_t;

    typedef struct packed {
        pal_mode_t               mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } pal_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        pal_status_t             status;
        logic [CNT_OUT_W-1:0]    count_after;
    } pal_rsp_t;

    // Broadcast controls for every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
        logic tap_load;
        logic tap_shift;
    } pal_ctl_t;

endpackage

`default_nettype wire

@@ design/positional_array_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "positional_array_list_defines.svh"

// Channel   Dir  Handshake              Payload
// request   in   start high, busy low   pal_req_t  (mode, position, item_value)
// result    out  done, one cycle        pal_rsp_t  (removed_value, status, count_after)
//
// Insert, append, every error and a removal at position 0 give their result in the
// cycle after the request is taken. For a removal at position p > 0 the removed
// value first walks down the tap row one cell per cycle, from cell p to cell 1.
// busy is high while that walk runs; start is ignored then.
// Reset clears the count; store contents stay undefined until written.
// done is high for exactly one cycle per result; the receiver cannot stall.

module positional_array_list #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pal_pkg::pal_req_t request,
    output logic              done,
    output pal_pkg::pal_rsp_t result
);
    import pal_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    logic [VAL_W-1:0] entry_w [CAPACITY];
    logic [VAL_W-1:0] tap_w   [CAPACITY];

    pal_ctl_t         ctl;
    logic [IDX_W-1:0] cell_target;

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] wait_reg;
    logic [IDX_W-1:0] wait_next;
    pal_rsp_t         result_reg;
    pal_rsp_t         result_next;

    logic             accept;
    logic             is_ins;
    logic             is_del;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] tgt;
    pal_status_t      st;

    assign accept    = start && !busy_reg;
    assign count_ext = CMP_W'(count_reg);

    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        tgt    = CMP_W'(request.position);
        unique case (request.mode)
            MODE_INSERT:
            begin
                is_ins = 1'b1;
            end
            MODE_APPEND:
            begin
                is_ins = 1'b1;
                tgt    = count_ext;
            end
            MODE_REMOVE:
            begin
                is_del = 1'b1;
            end
            MODE_REMOVE_LAST:
            begin
                is_del = 1'b1;
                tgt    = count_ext - CMP_W'(1);
            end
        endcase
    end

    always_comb
    begin
        st = ST_OK;
        if (is_ins)
        begin
            if (count_reg == CNT_W'(CAPACITY))
            begin
                st = ST_FULL;
            end
            else if (tgt > count_ext)
            begin
                st = ST_BADPOS;
            end
        end
        else if (is_del)
        begin
            if (count_reg == '0)
            begin
                st = ST_EMPTY;
            end
            else if (tgt >= count_ext)
            begin
                st = ST_BADPOS;
            end
        end
    end

    assign cell_target = tgt[IDX_W-1:0];

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        wait_next     = wait_reg;
        result_next   = result_reg;
        ctl           = '0;
        ctl.tap_shift = busy_reg;

        if (busy_reg)
        begin
            wait_next = wait_reg - IDX_W'(1);
            // Tap of cell 1 holds the target entry on the last step.
            if (wait_reg == IDX_W'(1))
            begin
                busy_next                 = 1'b0;
                done_next                 = 1'b1;
                result_next.removed_value = tap_w[1];
            end
        end
        else if (start)
        begin
            ctl.tap_load              = 1'b1;
            done_next                 = 1'b1;
            result_next.status        = st;
            result_next.removed_value = '0;
            if (st == ST_OK && is_ins)
            begin
                ctl.ins    = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            else if (st == ST_OK && is_del)
            begin
                ctl.del    = 1'b1;
                count_next = count_reg - CNT_W'(1);
                if (cell_target == '0)
                begin
                    result_next.removed_value = entry_w[0];
                end
                else
                begin
                    // Hold the beat until the value reaches cell 1 of the tap row.
                    done_next = 1'b0;
                    busy_next = 1'b1;
                    wait_next = cell_target;
                end
            end
            result_next.count_after = CNT_OUT_W'(count_next);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_w;
        logic [VAL_W-1:0] right_w;
        logic [VAL_W-1:0] right_tap_w;

        if (i == 0)
        begin : g_head
            assign left_w = entry_w[i];
        end
        else
        begin : g_body
            assign left_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_w     = entry_w[i];
            assign right_tap_w = tap_w[i];
        end
        else
        begin : g_inner
            assign right_w     = entry_w[i+1];
            assign right_tap_w = tap_w[i+1];
        end

        pal_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .target      (cell_target),
            .item_value  (request.item_value),
            .left_entry  (left_w),
            .right_entry (right_w),
            .right_tap   (right_tap_w),
            .entry       (entry_w[i]),
            .tap         (tap_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `PAL_ASSERT_NOW(a_busy_no_done, clk, rst_n, busy_reg, !done_reg, "result beat during busy")
    `PAL_ASSERT_NOW(a_count_match, clk, rst_n, done_reg,
        result_reg.count_after == CNT_OUT_W'(count_reg), "count_after differs from count")
    `PAL_ASSERT_NEXT(a_err_keeps_count, clk, rst_n, accept && st != ST_OK,
        done_reg && count_reg == $past(count_reg), "error changed the count")
    `PAL_ASSERT_NEXT(a_walk_ends, clk, rst_n, busy_reg && wait_reg == IDX_W'(1),
        done_reg && !busy_reg, "removal walk did not end in a result")

endmodule

`default_nettype wire

@@ design/pal_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pal_cell #(
    parameter int IDX_W = $clog2(pal_pkg::DEF_CAPACITY),
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  pal_pkg::pal_ctl_t        ctl,
    input  logic [IDX_W-1:0]         target,
    input  logic [pal_pkg::VAL_W-1:0] item_value,
    input  logic [pal_pkg::VAL_W-1:0] left_entry,
    input  logic [pal_pkg::VAL_W-1:0] right_entry,
    input  logic [pal_pkg::VAL_W-1:0] right_tap,
    output logic [pal_pkg::VAL_W-1:0] entry,
    output logic [pal_pkg::VAL_W-1:0] tap
);
    import pal_pkg::*;

    localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic [VAL_W-1:0] tap_reg;
    logic [VAL_W-1:0] tap_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (IDX == target)
            begin
                entry_next = item_value;
            end
            else if (IDX > target)
            begin
                entry_next = left_entry;
            end
        end
        else if (ctl.del && (IDX >= target))
        begin
            entry_next = right_entry;
        end
    end

    // Tap row: snapshot of the store, walked toward cell 0 one step a cycle while tap_shift is set.
    always_comb
    begin
        tap_next = tap_reg;
        if (ctl.tap_load)
        begin
            tap_next = entry_reg;
        end
        else if (ctl.tap_shift)
        begin
            tap_next = right_tap;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule

`default_nettype wire
